>>> hdl/ramt_pkg.sv
// ----------------------------------------------------------------------------
// ramt_pkg
// types and constants shared by the range-assign / range-min tree unit
// ----------------------------------------------------------------------------
package ramt_pkg;

    localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;
    localparam int IDX_W = 11;
    localparam int VAL_W = 32;

    typedef enum logic
    {
        FUNC_ASSIGN = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_CLEAR,
        ST_VISIT,
        ST_RD_WAIT,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_DECIDE,
        ST_RET_RD,
        ST_RET_WAIT,
        ST_RET_WR,
        ST_POP,
        ST_RESULT
    } state_t;

endpackage

>>> hdl/ramt_if.sv
// ----------------------------------------------------------------------------
// ramt_in_if / ramt_out_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
interface ramt_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic [10:0]         range_start;
    logic [10:0]         range_end;
    logic signed [31:0]  new_value;
    modport source (output valid, func, range_start, range_end, new_value, input ready);
    modport sink   (input valid, func, range_start, range_end, new_value, output ready);
endinterface

interface ramt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_min;
    modport source (output valid, range_min, input ready);
    modport sink   (input valid, range_min, output ready);
endinterface

>>> hdl/range_assign_range_min_tree_unit.sv
// ----------------------------------------------------------------------------
// range_assign_range_min_tree_unit
// lazy segment tree with range assign and range minimum query
// ----------------------------------------------------------------------------
// channel   dir   beat contents
// req       in    func, range_start, range_end, new_value
// rsp       out   range_min (one beat per query, none per assign)
//
// one request at a time, walked over the node memory (one read, one write
// port) under an explicit stack; every node visit ends in a pop cycle; a
// visit outside the span is the visit state alone, inside it adds read-wait
// and decide, push-left and push-right come in when a tag is passed down,
// and an assign rebuilds each split node's minimum in return read, wait and
// write; a full span stops at the root; after reset a clearing pass writes
// every node (2*LEAVES of them at a power of two)
// rst_n is asynchronous; a result waits in its output register until taken
// and holds off the next request meanwhile
// ----------------------------------------------------------------------------
module range_assign_range_min_tree_unit
    import ramt_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic   clk,
    input  logic   rst_n,
    ramt_in_if.sink    req,
    ramt_out_if.source rsp
);

    localparam int NODES  = 2 << $clog2(LEAVES);
    localparam int NW     = $clog2(NODES) + 1;     // node index, one spare bit
    localparam int AW     = $clog2(NODES);         // memory address
    localparam int RW     = $clog2(LEAVES + 1);    // range bound
    localparam int DEPTH  = $clog2(LEAVES) + 2;    // stack depth
    localparam int SW     = $clog2(DEPTH + 1);

    // node memory: {pending, tag, min}
    localparam int EW = 1 + 2 * VAL_W;
    logic [EW-1:0] mem [NODES];

    // memory port
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // stack of frames: node, lo, hi
    logic [NW-1:0] stk_k  [DEPTH];
    logic [RW-1:0] stk_l  [DEPTH];
    logic [RW-1:0] stk_r  [DEPTH];
    logic          stk_s  [DEPTH];   // second child entered
    logic [SW-1:0] sp_reg, sp_next;

    state_t state_reg, state_next;
    logic          func_reg;
    logic [RW-1:0] a_reg, b_reg;
    logic signed [VAL_W-1:0] x_reg, acc_reg, acc_next;
    logic [NW-1:0] k_reg, k_next;
    logic [RW-1:0] l_reg, l_next, r_reg, r_next;
    logic signed [VAL_W-1:0] tag_reg, min_reg, cmin_reg;
    logic [AW:0]   clr_reg;
    logic          ovalid_reg;
    logic signed [VAL_W-1:0] omin_reg;

    logic [RW-1:0] mid;
    logic          covers, is_leaf, outside;
    logic [NW-1:0] top_k;
    logic [RW-1:0] b_clip;
    logic          span_empty;
    logic          push_frame, pop_frame;

    assign mid     = RW'(({1'b0, l_reg} + {1'b0, r_reg}) >> 1);
    assign covers  = (a_reg <= l_reg) && (r_reg <= b_reg);
    assign is_leaf = (r_reg - l_reg) == RW'(1);
    assign outside = (b_reg <= l_reg) || (r_reg <= a_reg);
    assign top_k   = stk_k[sp_reg - SW'(1)];
    assign b_clip  = (int'(req.range_end) > LEAVES) ? RW'(LEAVES) : RW'(req.range_end);
    // nothing left once the end is clipped to the leaf count
    assign span_empty = int'(req.range_start) >= int'(b_clip);

    assign req.ready     = (state_reg == ST_IDLE) && !ovalid_reg;
    assign rsp.valid     = ovalid_reg;
    assign rsp.range_min = omin_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    if (span_empty)
                        state_next = (req.func == FUNC_QUERY) ? ST_RESULT : ST_IDLE;
                    else
                        state_next = ST_VISIT;
                end
            end
            ST_CLEAR:    state_next = (clr_reg == (AW+1)'(NODES - 1)) ? ST_IDLE : ST_CLEAR;
            ST_VISIT:    state_next = outside ? ST_POP : ST_RD_WAIT;
            ST_RD_WAIT:  state_next = (rdata_reg[EW-1] && !is_leaf) ? ST_PUSH_L : ST_DECIDE;
            ST_PUSH_L:   state_next = ST_PUSH_R;
            ST_PUSH_R:   state_next = ST_DECIDE;
            ST_DECIDE:   state_next = (covers || is_leaf) ? ST_POP : ST_VISIT;
            ST_RET_RD:   state_next = ST_RET_WAIT;
            ST_RET_WAIT: state_next = ST_RET_WR;
            ST_RET_WR:   state_next = ST_POP;
            ST_POP:
            begin
                if (sp_reg == '0)
                    state_next = (func_reg == FUNC_QUERY) ? ST_RESULT : ST_IDLE;
                else if (!stk_s[sp_reg - SW'(1)])
                    state_next = ST_VISIT;
                else
                    state_next = (func_reg == FUNC_ASSIGN) ? ST_RET_RD : ST_POP;
            end
            ST_RESULT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = k_reg[AW-1:0];
        k_next = k_reg;
        l_next = l_reg;
        r_next = r_reg;
        sp_next = sp_reg;
        acc_next = acc_reg;
        push_frame = 1'b0;
        pop_frame = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = {1'b0, {VAL_W{1'b0}}, MAX_VAL};
            end
            ST_IDLE:
            begin
                k_next = '0;
                l_next = '0;
                r_next = RW'(LEAVES);
                sp_next = '0;
                acc_next = MAX_VAL;
            end
            ST_RD_WAIT:
            begin
                // clear own tag now
                we = 1'b1;
                waddr = k_reg[AW-1:0];
                wdata = {1'b0, rdata_reg[EW-2:0]};
            end
            ST_PUSH_L:
            begin
                we = 1'b1;
                waddr = AW'(2 * k_reg + NW'(1));
                wdata = {1'b1, tag_reg, tag_reg};
            end
            ST_PUSH_R:
            begin
                we = 1'b1;
                waddr = AW'(2 * k_reg + NW'(2));
                wdata = {1'b1, tag_reg, tag_reg};
            end
            ST_DECIDE:
            begin
                if (covers || is_leaf)
                begin
                    if (func_reg == FUNC_ASSIGN)
                    begin
                        if (covers)
                        begin
                            we = 1'b1;
                            waddr = k_reg[AW-1:0];
                            wdata = {1'b1, x_reg, x_reg};
                        end
                    end
                    else if (covers && min_reg < acc_reg)
                        acc_next = min_reg;
                end
                else
                begin
                    // descend to lower child
                    push_frame = 1'b1;
                    sp_next = sp_reg + SW'(1);
                    k_next = NW'(2 * k_reg + NW'(1));
                    r_next = mid;
                end
            end
            ST_POP:
            begin
                if (sp_reg != '0 && !stk_s[sp_reg - SW'(1)])
                begin
                    k_next = NW'(2 * top_k + NW'(2));
                    l_next = RW'(({1'b0, stk_l[sp_reg - SW'(1)]}
                                 + {1'b0, stk_r[sp_reg - SW'(1)]}) >> 1);
                    r_next = stk_r[sp_reg - SW'(1)];
                end
                else if (sp_reg != '0 && func_reg == FUNC_ASSIGN)
                begin
                    raddr = AW'(2 * top_k + NW'(1));
                end
                else if (sp_reg != '0)
                begin
                    pop_frame = 1'b1;
                    sp_next = sp_reg - SW'(1);
                end
            end
            ST_RET_RD:
            begin
                raddr = AW'(2 * top_k + NW'(2));
            end
            ST_RET_WAIT:
            begin
                // hold the upper child on the read port for the write cycle
                raddr = AW'(2 * top_k + NW'(2));
            end
            ST_RET_WR:
            begin
                // parent tag was cleared on the way down
                we = 1'b1;
                waddr = top_k[AW-1:0];
                raddr = top_k[AW-1:0];
                wdata = {1'b0, {VAL_W{1'b0}},
                         (cmin_reg < $signed(rdata_reg[VAL_W-1:0])) ? cmin_reg
                                                                    : rdata_reg[VAL_W-1:0]};
                pop_frame = 1'b1;
                sp_next = sp_reg - SW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_WAIT)
        begin
            tag_reg  <= rdata_reg[EW-2:VAL_W];
            min_reg  <= rdata_reg[EW-1] ? rdata_reg[EW-2:VAL_W] : rdata_reg[VAL_W-1:0];
        end
        if (state_reg == ST_RET_RD)
            cmin_reg <= rdata_reg[VAL_W-1:0];
        if (state_reg == ST_IDLE && req.valid && req.ready)
        begin
            func_reg <= req.func;
            a_reg <= RW'(req.range_start);
            b_reg <= b_clip;
            x_reg <= req.new_value;
        end
        if (push_frame)
        begin
            stk_k[sp_reg] <= k_reg;
            stk_l[sp_reg] <= l_reg;
            stk_r[sp_reg] <= r_reg;
            stk_s[sp_reg] <= 1'b0;
        end
        if (state_reg == ST_POP && sp_reg != '0 && !stk_s[sp_reg - SW'(1)])
            stk_s[sp_reg - SW'(1)] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            sp_reg     <= '0;
            k_reg      <= '0;
            l_reg      <= '0;
            r_reg      <= '0;
            acc_reg    <= MAX_VAL;
            ovalid_reg <= 1'b0;
            omin_reg   <= MAX_VAL;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            k_reg     <= k_next;
            l_reg     <= l_next;
            r_reg     <= r_next;
            acc_reg   <= acc_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + (AW+1)'(1);
            if (rsp.valid && rsp.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_RESULT)
            begin
                ovalid_reg <= 1'b1;
                omin_reg   <= acc_reg;
            end
        end
    end

endmodule
